// ===== rtl/pcm_pkg.sv =====
package pcm_pkg;

  // Channel and sample store geometry
  localparam int CHAN_CNT  = 4;
  localparam int CHAN_W    = 2;
  localparam int SAMPLES   = 1024;
  localparam int ADDR_W    = $clog2(SAMPLES);

  // Field widths of the item ports
  localparam int ADDR_IN_W = 10;
  localparam int SAMPLE_W  = 8;
  localparam int LEN_W     = 11;
  localparam int GAIN_W    = 7;

  // Mixing constants
  localparam int FADE_TICKS = 4;
  localparam int FADE_SH    = $clog2(FADE_TICKS);
  localparam int FC_W       = 3;
  localparam int SUM_SHIFT  = 6;
  localparam int ACC_W      = 16;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // Command codes on the input port
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_START,
    OP_TICK
  } op_t;

  // Classified command as queued for the back end
  typedef struct packed {
    op_t                        op;
    logic [CHAN_W-1:0]          chan;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] value;
    logic [ADDR_W-1:0]          last;
    logic [GAIN_W-1:0]          gain;
    logic                       loop_en;
  } cmd_t;

endpackage

// ===== rtl/pcm_front.sv =====
module pcm_front (
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_command,
  input  logic [pcm_pkg::CHAN_W-1:0]           in_chan,
  input  logic [pcm_pkg::ADDR_IN_W-1:0]        in_sample_addr,
  input  logic signed [pcm_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic [pcm_pkg::LEN_W-1:0]            in_play_length,
  input  logic [pcm_pkg::GAIN_W-1:0]           in_volume,
  input  logic                                 in_loop_enable,
  input  logic                                 q_full,
  output logic                                 q_push,
  output pcm_pkg::cmd_t                        q_entry
);
  import pcm_pkg::*;

  logic keep;

  // Take an item whenever the queue has room
  assign in_ready = !q_full;

  // Decode the command (unknown codes are dropped here); payload: address is used as the
  // bank index, length becomes a last index
  always_comb begin
    keep       = 1'b1;
    q_entry.op = OP_TICK;
    case (in_command)
      CMD_WRITE: q_entry.op = OP_WRITE;
      CMD_START: q_entry.op = OP_START;
      CMD_TICK:  q_entry.op = OP_TICK;
      default:   keep = 1'b0;
    endcase
    q_entry.chan    = in_chan;
    q_entry.addr    = ADDR_W'(in_sample_addr);
    q_entry.value   = in_sample_value;
    q_entry.gain    = in_volume;
    q_entry.loop_en = in_loop_enable;
    if (in_play_length == '0) begin
      q_entry.last = '0;
    end else if (32'(in_play_length) > 32'(SAMPLES)) begin
      q_entry.last = ADDR_W'(SAMPLES - 1);
    end else begin
      q_entry.last = ADDR_W'(in_play_length - LEN_W'(1));
    end
  end

  assign q_push = in_valid && in_ready && keep;

endmodule

// ===== rtl/pcm_fifo.sv =====
module pcm_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pcm_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output pcm_pkg::cmd_t dout,
  output logic          empty
);
  import pcm_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/pcm_back.sv =====
module pcm_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pcm_pkg::cmd_t                        q_data,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pcm_pkg::SAMPLE_W-1:0]  out_mixed_sample
);
  import pcm_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_PLAY,
    MODE_FADE
  } mode_t;

  // Per-channel playback state
  logic [ADDR_W-1:0]          pos_r     [CHAN_CNT];
  logic [ADDR_W-1:0]          last_r    [CHAN_CNT];
  logic [GAIN_W-1:0]          gain_r    [CHAN_CNT];
  logic                       loop_r    [CHAN_CNT];
  logic                       playing_r [CHAN_CNT];
  logic [FC_W-1:0]            fc_r      [CHAN_CNT];
  logic signed [SAMPLE_W-1:0] held_r    [CHAN_CNT];

  // Stage B: read data and what each channel does this tick
  logic                       b_valid_r;
  mode_t                      b_mode_r  [CHAN_CNT];
  logic [GAIN_W-1:0]          b_gain_r  [CHAN_CNT];
  logic [FC_W-1:0]            b_fc_r    [CHAN_CNT];
  logic signed [SAMPLE_W-1:0] rdata_r   [CHAN_CNT];
  logic signed [ACC_W-1:0]    term_b    [CHAN_CNT];

  // Stage C: channel contributions
  logic                       c_valid_r;
  logic signed [ACC_W-1:0]    c_term_r  [CHAN_CNT];

  // Output stage
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic signed [SAMPLE_W-1:0] prev_r;

  logic                       adv;
  logic                       is_write;
  logic                       is_start;
  logic                       is_tick;
  logic [ACC_W-1:0]           acc;
  logic signed [SAMPLE_W-1:0] cur;
  logic [SAMPLE_W:0]          avg;

  // The whole back pipeline moves when the output register can take a result
  assign adv      = !out_valid_r || out_ready;
  assign q_pop    = adv && !q_empty;
  assign is_write = q_pop && (q_data.op == OP_WRITE);
  assign is_start = q_pop && (q_data.op == OP_START);
  assign is_tick  = q_pop && (q_data.op == OP_TICK);

  // Sample banks, one per channel, each read at its own play position
  for (genvar g = 0; g < CHAN_CNT; g++) begin : g_bank
    logic [SAMPLE_W-1:0] mem [SAMPLES];

    always_ff @(posedge clk) begin
      if (is_write && q_data.chan == CHAN_W'(g)) begin
        mem[q_data.addr] <= q_data.value;
      end
      if (adv) begin
        rdata_r[g] <= mem[pos_r[g]];
      end
    end
  end

  // Stage A: start commands and per-tick position update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      for (int c = 0; c < CHAN_CNT; c++) begin
        pos_r[c]     <= '0;
        last_r[c]    <= '0;
        gain_r[c]    <= '0;
        loop_r[c]    <= 1'b0;
        playing_r[c] <= 1'b0;
        fc_r[c]      <= '0;
        b_mode_r[c]  <= MODE_IDLE;
        b_gain_r[c]  <= '0;
        b_fc_r[c]    <= '0;
      end
    end else if (adv) begin
      b_valid_r <= is_tick;
      for (int c = 0; c < CHAN_CNT; c++) begin
        b_mode_r[c] <= MODE_IDLE;
        b_gain_r[c] <= gain_r[c];
        b_fc_r[c]   <= fc_r[c];
        if (is_start && q_data.chan == CHAN_W'(c)) begin
          last_r[c]    <= q_data.last;
          gain_r[c]    <= q_data.gain;
          loop_r[c]    <= q_data.loop_en;
          pos_r[c]     <= '0;
          playing_r[c] <= 1'b1;
          fc_r[c]      <= '0;
        end else if (is_tick) begin
          if (playing_r[c]) begin
            b_mode_r[c] <= MODE_PLAY;
            if (pos_r[c] >= last_r[c]) begin
              pos_r[c] <= '0;
              if (!loop_r[c]) begin
                playing_r[c] <= 1'b0;
                fc_r[c]      <= FC_W'(FADE_TICKS);
              end
            end else begin
              pos_r[c] <= pos_r[c] + ADDR_W'(1);
            end
          end else if (fc_r[c] != '0) begin
            b_mode_r[c] <= MODE_FADE;
            fc_r[c]     <= fc_r[c] - FC_W'(1);
          end
        end
      end
    end
  end

  // Stage B: scale by gain, or fade the held sample (truncated toward zero)
  always_comb begin
    logic signed [ACC_W-1:0] s16;
    logic signed [ACC_W-1:0] f16;
    s16 = '0;
    f16 = '0;
    for (int c = 0; c < CHAN_CNT; c++) begin
      term_b[c] = '0;
      case (b_mode_r[c])
        MODE_PLAY: begin
          s16       = ACC_W'(rdata_r[c]);
          term_b[c] = s16 * $signed(ACC_W'(b_gain_r[c]));
        end
        MODE_FADE: begin
          s16 = ACC_W'(held_r[c]);
          f16 = s16 * $signed(ACC_W'(b_fc_r[c]));
          if (f16[ACC_W-1]) begin
            f16 = f16 + ACC_W'(FADE_TICKS - 1);
          end
          term_b[c] = f16 >>> FADE_SH;
        end
        default: term_b[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      for (int c = 0; c < CHAN_CNT; c++) begin
        held_r[c] <= '0;
      end
    end else if (adv) begin
      c_valid_r <= b_valid_r;
      for (int c = 0; c < CHAN_CNT; c++) begin
        c_term_r[c] <= term_b[c];
        if (b_valid_r && b_mode_r[c] == MODE_PLAY) begin
          held_r[c] <= rdata_r[c];
        end
      end
    end
  end

  // Stage C: wrap-around sum, scale down, average with the previous byte
  always_comb begin
    acc = '0;
    for (int c = 0; c < CHAN_CNT; c++) begin
      acc = acc + c_term_r[c];
    end
    cur = acc[SUM_SHIFT+SAMPLE_W-1:SUM_SHIFT];
    avg = {cur[SAMPLE_W-1], cur} + {prev_r[SAMPLE_W-1], prev_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_r      <= '0;
    end else if (adv) begin
      out_valid_r <= c_valid_r;
      if (c_valid_r) begin
        out_sample_r <= avg[SAMPLE_W:1];
        prev_r       <= cur;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_sample_r;

  // Checks on channel bookkeeping and pipeline hold
  for (genvar g = 0; g < CHAN_CNT; g++) begin : g_chk
    a_play_no_fade: assert property (@(posedge clk) disable iff (!rst_n)
      playing_r[g] |-> (fc_r[g] == '0))
      else $error("channel playing with fade pending");
    a_fade_bound: assert property (@(posedge clk) disable iff (!rst_n)
      fc_r[g] <= FC_W'(FADE_TICKS))
      else $error("fade count out of range");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
      playing_r[g] |-> (pos_r[g] <= last_r[g]))
      else $error("play position past end");
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && !adv) |=> c_valid_r)
    else $error("tick lost during output stall");

endmodule

// ===== rtl/pcm_channel_mixer_unit.sv =====
// Four-channel 8-bit PCM mixer. Commands arrive as items: write stores a sample in a
// channel's bank, start arms a channel (length, volume, loop), tick mixes one output
// byte and is the only command that returns an item. The block takes one item per
// cycle while the queue has room; a tick's result passes through the queue, the bank
// read register, the channel term register and the averaging output register, and is
// held while out_ready is low. Each channel has its own 1024-byte bank read at its own
// play position, which is what lets ticks follow each other every cycle while the
// output is not stalled. Banks are not cleared: reading a sample that was never written
// gives an undefined value. A two-item queue separates input acceptance from execution,
// so a stalled output only holds off input once the queue is full.
module pcm_channel_mixer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_command,
  input  logic [pcm_pkg::CHAN_W-1:0]           in_chan,
  input  logic [pcm_pkg::ADDR_IN_W-1:0]        in_sample_addr,
  input  logic signed [pcm_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic [pcm_pkg::LEN_W-1:0]            in_play_length,
  input  logic [pcm_pkg::GAIN_W-1:0]           in_volume,
  input  logic                                 in_loop_enable,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pcm_pkg::SAMPLE_W-1:0]  out_mixed_sample
);
  import pcm_pkg::*;

  cmd_t q_entry;
  cmd_t q_data;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // Front: accept and classify items
  pcm_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_chan         (in_chan),
    .in_sample_addr  (in_sample_addr),
    .in_sample_value (in_sample_value),
    .in_play_length  (in_play_length),
    .in_volume       (in_volume),
    .in_loop_enable  (in_loop_enable),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  // Command queue
  pcm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_entry),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty)
  );

  // Back: banks, channel state and mixing pipeline
  pcm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_data           (q_data),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mixed_sample (out_mixed_sample)
  );

endmodule
